// ----- rtl/mup_pkg.sv -----
// Shared types, codes and tables of the MIDI byte to USB-MIDI packet parser.
`timescale 1ns / 1ps
package mup_pkg;

    // Input modes as they arrive on the port
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_POLL = 2'd2;

    // Item kinds after classification
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_STATUS   = 3'd1;
    localparam logic [2:0] KIND_REALTIME = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_POLL     = 3'd4;

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_SYS_2B    = 4'h2;
    localparam logic [3:0] CIN_SYS_3B    = 4'h3;
    localparam logic [3:0] CIN_SYSEX     = 4'h4;
    localparam logic [3:0] CIN_END_1B    = 4'h5;
    localparam logic [3:0] CIN_END_2B    = 4'h6;
    localparam logic [3:0] CIN_END_3B    = 4'h7;
    localparam logic [3:0] CIN_REALTIME  = 4'hF;
    localparam logic [3:0] CIN_NONE      = 4'h0;

    localparam logic [7:0]  SYSEX_START   = 8'hF0;
    localparam logic [7:0]  SYSEX_END     = 8'hF7;
    localparam logic [7:0]  REALTIME_MIN  = 8'hF8;
    localparam logic [3:0]  SYSTEM_NIBBLE = 4'hF;
    localparam logic [15:0] LIMIT_RESET   = 16'd1000;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    localparam logic STATUS_PACKET  = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] port;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic       status;
        logic [1:0] port;
        logic [3:0] code_index;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_result;

    // Number of data bytes that follow a status byte
    function automatic logic [1:0] f_msg_len(input logic [7:0] b);
        logic [1:0] len;
        case (b[6:4])
            3'd4, 3'd5: len = 2'd1;
            3'd7: begin
                case (b[3:0])
                    4'h0, 4'h1, 4'h3: len = 2'd1;
                    4'h2:             len = 2'd2;
                    default:          len = 2'd0;
                endcase
            end
            default: len = 2'd2;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/mup_front.sv -----
// Front end: accepts input items, classifies them and drops the ones that do nothing.
`timescale 1ns / 1ps
module mup_front #(
    parameter int PORTS = 4
) (
    input  logic          i_valid,
    input  logic [1:0]    i_mode,
    input  logic [1:0]    i_port_number,
    input  logic [7:0]    i_data_byte,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output mup_pkg::t_cmd o_cmd
);
    import mup_pkg::*;

    logic keep;

    always_comb begin
        keep        = 1'b0;
        o_cmd.kind  = KIND_POLL;
        o_cmd.port  = i_port_number;
        o_cmd.data  = i_data_byte;
        case (i_mode)
            MODE_TICK: begin
                keep       = 1'b1;
                o_cmd.kind = KIND_TICK;
            end
            MODE_BYTE: begin
                keep = (32'(i_port_number) < PORTS);
                if (!i_data_byte[7]) begin
                    o_cmd.kind = KIND_DATA;
                end else if (i_data_byte >= REALTIME_MIN) begin
                    o_cmd.kind = KIND_REALTIME;
                end else begin
                    o_cmd.kind = KIND_STATUS;
                end
            end
            MODE_POLL: begin
                keep       = (32'(i_port_number) < PORTS);
                o_cmd.kind = KIND_POLL;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

// ----- rtl/mup_fifo.sv -----
// Small register queue between the front end and the back end.
`timescale 1ns / 1ps
module mup_fifo #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ----- rtl/mup_back.sv -----
// Back end: per-port parse records, timeout check and the output register.
`timescale 1ns / 1ps
module mup_back #(
    parameter int PORTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_limit_we,
    input  logic [15:0]      i_limit,
    input  logic             i_cmd_valid,
    input  mup_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_res_valid,
    input  logic             i_res_stall,
    output mup_pkg::t_result o_res
);
    import mup_pkg::*;

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

    logic [7:0]  r_cur  [PORTS], n_cur  [PORTS];
    logic [1:0]  r_exp  [PORTS], n_exp  [PORTS];
    logic [1:0]  r_wait [PORTS], n_wait [PORTS];
    logic [1:0]  r_sx   [PORTS], n_sx   [PORTS];
    logic [3:0]  r_pc   [PORTS], n_pc   [PORTS];
    logic [23:0] r_pb   [PORTS], n_pb   [PORTS];
    logic [15:0] r_it   [PORTS], n_it   [PORTS];
    logic [15:0] r_limit;
    logic        r_ovalid, n_ovalid;
    t_result     r_res, n_res;

    logic [PW-1:0] p;

    assign p     = PW'(i_cmd.port);
    assign o_pop = i_cmd_valid && (!r_ovalid || !i_res_stall);

    always_comb begin
        logic [7:0]  b;
        logic [7:0]  v_cur;
        logic [1:0]  v_exp, v_wait, v_sx;
        logic [3:0]  v_pc;
        logic [23:0] v_pb;
        logic [15:0] v_it;
        logic        done, rt, have;

        n_cur    = r_cur;
        n_exp    = r_exp;
        n_wait   = r_wait;
        n_sx     = r_sx;
        n_pc     = r_pc;
        n_pb     = r_pb;
        n_it     = r_it;
        n_ovalid = r_ovalid && i_res_stall;
        n_res    = r_res;

        b      = i_cmd.data;
        v_cur  = r_cur[p];
        v_exp  = r_exp[p];
        v_wait = r_wait[p];
        v_sx   = r_sx[p];
        v_pc   = r_pc[p];
        v_pb   = r_pb[p];
        v_it   = r_it[p];
        done   = 1'b0;
        rt     = 1'b0;
        have   = 1'b0;

        if (o_pop) begin
            case (i_cmd.kind)
                KIND_TICK: begin
                    for (int k = 0; k < PORTS; k++) begin
                        if (r_it[k] != TICK_MAX) begin
                            n_it[k] = r_it[k] + 16'd1;
                        end
                    end
                end
                KIND_REALTIME: begin
                    rt = 1'b1;
                end
                KIND_STATUS: begin
                    v_cur = b;
                    v_exp = f_msg_len(b);
                    if (b == SYSEX_START) begin
                        v_pb[7:0] = SYSEX_START;
                        v_sx      = 2'd1;
                    end else if (b == SYSEX_END) begin
                        case (v_sx)
                            2'd0: begin
                                v_pc = CIN_END_1B;
                                v_pb = {16'd0, SYSEX_END};
                            end
                            2'd1: begin
                                v_pc        = CIN_END_2B;
                                v_pb[23:8]  = {8'd0, SYSEX_END};
                            end
                            default: begin
                                v_pc         = CIN_END_3B;
                                v_pb[23:16]  = SYSEX_END;
                            end
                        endcase
                        v_sx = 2'd0;
                        done = 1'b1;
                    end else begin
                        v_sx = 2'd0;
                        if (v_exp == 2'd0) begin
                            v_pc = CIN_END_1B;
                            v_pb = {16'd0, b};
                            done = 1'b1;
                        end
                    end
                    v_wait = v_exp;
                    v_it   = '0;
                end
                KIND_DATA: begin
                    if (v_cur == SYSEX_START) begin
                        // Collect SysEx data three bytes to a packet
                        case (v_sx)
                            2'd0: begin
                                v_pb[7:0] = b;
                                v_sx      = 2'd1;
                            end
                            2'd1: begin
                                v_pb[15:8] = b;
                                v_sx       = 2'd2;
                            end
                            default: begin
                                v_pb[23:16] = b;
                                v_pc        = CIN_SYSEX;
                                v_sx        = 2'd0;
                                done        = 1'b1;
                            end
                        endcase
                    end else if (v_exp != 2'd0) begin
                        if (v_wait == 2'd0) begin
                            v_wait = v_exp - 2'd1;
                            v_it   = '0;
                        end else begin
                            v_wait = v_wait - 2'd1;
                        end
                        if (v_exp == 2'd1) begin
                            v_pb[23:8] = {8'd0, b};
                        end else if (v_wait != 2'd0) begin
                            v_pb[15:8] = b;
                        end else begin
                            v_pb[23:16] = b;
                        end
                        if (v_wait == 2'd0) begin
                            if (v_cur[7:4] != SYSTEM_NIBBLE) begin
                                v_pc = v_cur[7:4];
                            end else begin
                                v_pc = (v_exp == 2'd1) ? CIN_SYS_2B : CIN_SYS_3B;
                            end
                            v_pb[7:0] = v_cur;
                            done      = 1'b1;
                        end
                    end
                end
                default: begin
                    // Poll: only the timeout check below
                end
            endcase

            if (i_cmd.kind != KIND_TICK) begin
                n_res.status     = STATUS_PACKET;
                n_res.port       = i_cmd.port;
                n_res.code_index = v_pc;
                n_res.byte0      = v_pb[7:0];
                n_res.byte1      = v_pb[15:8];
                n_res.byte2      = v_pb[23:16];
                have             = done;
                if (!done && rt) begin
                    have             = 1'b1;
                    n_res.code_index = CIN_REALTIME;
                    n_res.byte0      = b;
                    n_res.byte1      = '0;
                    n_res.byte2      = '0;
                end
                if (v_wait != 2'd0 && v_it > r_limit) begin
                    // Drop the stale record and report it
                    v_cur  = '0;
                    v_exp  = '0;
                    v_wait = '0;
                    v_sx   = '0;
                    v_pc   = '0;
                    v_pb   = '0;
                    v_it   = '0;
                    have             = 1'b1;
                    n_res.status     = STATUS_TIMEOUT;
                    n_res.code_index = CIN_NONE;
                    n_res.byte0      = '0;
                    n_res.byte1      = '0;
                    n_res.byte2      = '0;
                end
                n_cur[p]  = v_cur;
                n_exp[p]  = v_exp;
                n_wait[p] = v_wait;
                n_sx[p]   = v_sx;
                n_pc[p]   = v_pc;
                n_pb[p]   = v_pb;
                n_it[p]   = v_it;
                n_ovalid  = have;
                if (!have) begin
                    n_res = r_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '{default: '0};
            r_exp    <= '{default: '0};
            r_wait   <= '{default: '0};
            r_sx     <= '{default: '0};
            r_pc     <= '{default: '0};
            r_pb     <= '{default: '0};
            r_it     <= '{default: '0};
            r_limit  <= LIMIT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_cur    <= n_cur;
            r_exp    <= n_exp;
            r_wait   <= n_wait;
            r_sx     <= n_sx;
            r_pc     <= n_pc;
            r_pb     <= n_pb;
            r_it     <= n_it;
            r_ovalid <= n_ovalid;
            if (i_limit_we) begin
                r_limit <= i_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

// ----- rtl/midi_byte_to_usb_packet_parser.sv -----
// Top level of the MIDI byte stream to USB-MIDI event packet parser.
// Path: an accepted item is held in the queue register, then its result in the
//   back end's output register.
// Throughput, no stall: one item per cycle; the back end updates one port record per
//   cycle from the queue head, a tick updates all idle counters in that cycle.
// Reset (synchronous, active low): empties the queue, clears every port record,
//   drops the output item and loads timeout_limit with 1000. No clearing pass.
`timescale 1ns / 1ps
module midi_byte_to_usb_packet_parser #(
    parameter int PORTS       = 4,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write
    input  logic        i_timeout_limit_we,
    input  logic [15:0] i_timeout_limit,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_port_number,
    input  logic [7:0]  i_data_byte,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [1:0]  o_out_port,
    output logic [3:0]  o_code_index,
    output logic [7:0]  o_event_byte0,
    output logic [7:0]  o_event_byte1,
    output logic [7:0]  o_event_byte2
);
    import mup_pkg::*;

    t_cmd            front_cmd;
    logic            front_push;
    logic            q_full;
    logic            q_valid;
    logic [$bits(t_cmd)-1:0] q_rdata;
    t_cmd            q_cmd;
    logic            back_pop;
    t_result         back_res;

    // Classify each item; ticks always pass, bad ports and mode 3 drop here
    mup_front #(
        .PORTS (PORTS)
    ) u_front (
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_port_number (i_port_number),
        .i_data_byte   (i_data_byte),
        .i_full        (q_full),
        .o_stall       (o_stall),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    // Hold classified items so the input side keeps moving while the output stalls
    mup_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign q_cmd = t_cmd'(q_rdata);

    // Parse against the port record and load the output register
    mup_back #(
        .PORTS (PORTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit_we  (i_timeout_limit_we),
        .i_limit     (i_timeout_limit),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (back_pop),
        .o_res_valid (o_valid),
        .i_res_stall (i_stall),
        .o_res       (back_res)
    );

    assign o_status      = back_res.status;
    assign o_out_port    = back_res.port;
    assign o_code_index  = back_res.code_index;
    assign o_event_byte0 = back_res.byte0;
    assign o_event_byte1 = back_res.byte1;
    assign o_event_byte2 = back_res.byte2;

    // A full queue always has a head for the back end
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_valid)
        else $error("queue full but empty head");

    // Timeout results carry no packet contents
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_TIMEOUT) |->
        (o_code_index == CIN_NONE && o_event_byte0 == 8'd0 &&
         o_event_byte1 == 8'd0 && o_event_byte2 == 8'd0))
        else $error("timeout result with packet data");

    // Realtime code only ever carries a realtime byte
    a_realtime_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_PACKET && o_code_index == CIN_REALTIME) |->
        (o_event_byte0 >= REALTIME_MIN))
        else $error("realtime code without realtime byte");

    // Reset drops the output item
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
